// File: hw/rtl/ones_complement_sum_stream_assert.svh
// Assertion macros for the ones' complement checksum stream block.
// Depends on signals named clk and rst_n at the place of use.
// Simulation gets real assertions; synthesis gets empty bodies.
`ifndef ONES_COMPLEMENT_SUM_STREAM_ASSERT_SVH
`define ONES_COMPLEMENT_SUM_STREAM_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion, switched off while reset is held.
`define OCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define OCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OCS_ASSERT(lbl, prop, msg)
`define OCS_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/ocs_pkg.sv
// Shared constants and types for the ones' complement checksum stream block.
// No dependencies; imported by ones_complement_sum_stream, ocs_stream_checker and tb.
`default_nettype none

package ocs_pkg;

  // Fixed field widths of the stream transactions.
  localparam int DATA_W       = 64;
  localparam int DATA_BYTES   = DATA_W / 8;
  localparam int COUNT_W      = 4;
  localparam int SUM_W        = 16;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 24;

  // Sum of up to DATA_BYTES / 2 bytes of one lane parity.
  localparam int HALF_ACC_W   = 11;
  // Weighted total before folding: high half shifted up by one byte.
  localparam int WIDE_W       = HALF_ACC_W + 8 + 1;

  // Default lane count of the data path.
  localparam int LANES_DEF    = 8;

  // Contents of the first pipeline register. Both phase variants of the
  // folded item total are kept so the running loop only selects one.
  typedef struct packed {
    logic [SUM_W-1:0] fold_even;
    logic [SUM_W-1:0] fold_odd;
    logic             cnt_odd;
    logic             start;
  } ocs_stage_t;

endpackage

`default_nettype wire

// File: hw/rtl/ones_complement_sum_stream.sv
// Pipeline: an accepted transaction is registered in the stage-one register, then folded
// into the running-sum result register that drives out_*. Throughput: one transaction per clock
// while out_tready is high. The rate is set by the accumulate loop on the 16-bit running sum.
// Reset (rst_n low, synchronous) empties both pipeline registers and clears
// the running sum to zero and the byte phase to even.
// Depends on ocs_pkg and ones_complement_sum_stream_assert.svh.
`default_nettype none

`include "ones_complement_sum_stream_assert.svh"

module ones_complement_sum_stream
  import ocs_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  // Input stream. in_tdata, from bit 0 up: data_bytes[63:0], byte_count[67:64],
  // zero fill [71:68].
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: start_new (bit 0).
  input  wire logic                   in_tuser,

  // Result stream. out_tdata, from bit 0 up: running_sum[15:0], odd_phase[16],
  // zero fill [23:17].
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata
);

  // Only the first eight lanes carry data; lanes above that read as zero
  // and only advance the byte phase.
  localparam int   DATA_LANES = (LANES < DATA_BYTES) ? LANES : DATA_BYTES;
  localparam logic LANES_ODD  = 1'(LANES % 2);

  // Two-step end-around carry fold of the weighted item total.
  function automatic logic [SUM_W-1:0] fold_wide(input logic [WIDE_W-1:0] w);
    logic [SUM_W:0] t;
    t = {1'b0, w[SUM_W-1:0]} + {{(SUM_W+1-(WIDE_W-SUM_W)){1'b0}}, w[WIDE_W-1:SUM_W]};
    return t[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, t[SUM_W]};
  endfunction

  // --------------------------------------------------------------------
  // Input unpacking.
  // --------------------------------------------------------------------
  logic [DATA_W-1:0]  in_data;
  logic [COUNT_W-1:0] in_count;

  assign in_data  = in_tdata[DATA_W-1:0];
  assign in_count = in_tdata[DATA_W +: COUNT_W];

  // --------------------------------------------------------------------
  // Stage one: split the valid bytes by lane parity and fold the item total
  // for both possible starting phases. This part does not depend on the
  // running state, so it sits before the accumulate loop.
  // --------------------------------------------------------------------
  logic [HALF_ACC_W-1:0] even_acc;
  logic [HALF_ACC_W-1:0] odd_acc;
  logic                  cnt_odd;
  ocs_stage_t            stage_nxt;

  always_comb begin
    even_acc = '0;
    odd_acc  = '0;
    for (int k = 0; k < DATA_LANES; k++) begin
      if ({{(32-COUNT_W){1'b0}}, in_count} > 32'(k)) begin
        if ((k % 2) == 0) begin
          even_acc = even_acc + {{(HALF_ACC_W-8){1'b0}}, in_data[8*k +: 8]};
        end else begin
          odd_acc = odd_acc + {{(HALF_ACC_W-8){1'b0}}, in_data[8*k +: 8]};
        end
      end
    end
  end

  // Counts above the lane count are clipped to it, so only its parity matters.
  assign cnt_odd = ({{(32-COUNT_W){1'b0}}, in_count} > 32'(LANES)) ? LANES_ODD : in_count[0];

  always_comb begin
    // Even phase at item start: lane 0 is the low byte of a word.
    stage_nxt.fold_even = fold_wide({1'b0, odd_acc, 8'h00} + {9'd0, even_acc});
    // Odd phase at item start: lane 0 is the high byte of a word.
    stage_nxt.fold_odd  = fold_wide({1'b0, even_acc, 8'h00} + {9'd0, odd_acc});
    stage_nxt.cnt_odd   = cnt_odd;
    stage_nxt.start     = in_tuser;
  end

  // --------------------------------------------------------------------
  // Handshake. The running state doubles as the result register: a new
  // transaction is folded in once the previous result has been taken.
  // While a result waits, the stage-one register accepts only if it is empty.
  // --------------------------------------------------------------------
  ocs_stage_t       stage_r;
  logic             stage_valid_r;
  logic             out_valid_r;
  logic [SUM_W-1:0] sum_r;
  logic             phase_r;
  logic             out_load;
  logic             in_fire;

  assign out_load  = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_r <= stage_nxt;
    end
  end

  // --------------------------------------------------------------------
  // Stage two: the accumulate loop. A start flag clears the sum and the
  // phase before this transaction is added. One end-around fold is enough
  // here because two 16-bit values sum to at most 17 bits.
  // --------------------------------------------------------------------
  logic [SUM_W-1:0] base_sum;
  logic             base_phase;
  logic [SUM_W-1:0] item_fold;
  logic [SUM_W:0]   raw_sum;
  logic [SUM_W-1:0] sum_nxt;
  logic             phase_nxt;

  always_comb begin
    base_sum   = stage_r.start ? '0 : sum_r;
    base_phase = stage_r.start ? 1'b0 : phase_r;
    item_fold  = base_phase ? stage_r.fold_odd : stage_r.fold_even;
    raw_sum    = {1'b0, base_sum} + {1'b0, item_fold};
    sum_nxt    = raw_sum[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, raw_sum[SUM_W]};
    phase_nxt  = base_phase ^ stage_r.cnt_odd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        sum_r   <= sum_nxt;
        phase_r <= phase_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-SUM_W-1){1'b0}}, phase_r, sum_r};

  // --------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------
  // Adding a nonzero folded total can never give a zero sum.
  `OCS_ASSERT(a_nonzero_add, out_load && (item_fold != '0) |=> (sum_r != '0), "sum went to zero after nonzero add")
  // After a start flag, the new phase is just the item's byte count parity.
  `OCS_ASSERT(a_start_phase, out_load && stage_r.start |=> (phase_r == $past(stage_r.cnt_odd)), "phase not restarted on start")
  // An occupied first stage only takes a new transaction while it drains.
  `OCS_ASSERT(a_no_overwrite, in_fire && stage_valid_r |-> out_load, "stage one overwritten")
  // Reset leaves both pipeline registers empty.
  `OCS_ASSERT_RST(a_reset_empty, !rst_n |=> !stage_valid_r && !out_valid_r && (sum_r == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire

// File: tb/ocs_stream_checker.sv
// Scoreboard for the ones' complement checksum stream: watches both stream channels,
// predicts each result from the accepted input transactions and compares them in order.
// Depends on ocs_pkg for the field widths.
`timescale 1ns / 1ps

module ocs_stream_checker
  import ocs_pkg::*;
#(
  parameter int LANES = LANES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             odd;
  } csum_state_t;

  csum_state_t checksum_acc;
  csum_state_t expected_sums[$];
  int          errors;

  // Folds carries out of the low 16 bits back in, twice, so any 32-bit
  // total lands in 16 bits.
  function automatic logic [SUM_W-1:0] end_around_fold(input logic [31:0] value);
    logic [31:0] v;
    v = {16'h0, value[15:0]} + {16'h0, value[31:16]};
    v = {16'h0, v[15:0]} + {16'h0, v[31:16]};
    return v[SUM_W-1:0];
  endfunction

  // Adds one transaction's valid bytes into the running sum. Bytes at an
  // odd stream position weigh as the high half of a word.
  function automatic csum_state_t checksum_advance(input csum_state_t acc,
                                                   input logic [DATA_W-1:0] data,
                                                   input logic [COUNT_W-1:0] count,
                                                   input logic start);
    csum_state_t nxt;
    logic [31:0] total;
    logic [7:0]  b;
    int          n;
    nxt   = start ? '0 : acc;
    n     = (int'(count) > LANES) ? LANES : int'(count);
    total = '0;
    for (int k = 0; k < n; k++) begin
      // Lanes past the data word shift out to zero but still flip the phase.
      b = 8'(data >> (8 * k));
      total += nxt.odd ? {16'h0, b, 8'h00} : {24'h0, b};
      nxt.odd = ~nxt.odd;
    end
    nxt.sum = end_around_fold({16'h0, nxt.sum} + {16'h0, end_around_fold(total)});
    return nxt;
  endfunction

  always @(posedge clk) begin
    csum_state_t want;
    if (!rst_n) begin
      checksum_acc = '0;
      expected_sums.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result transaction: out_tdata %h", out_tdata);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (out_tdata[SUM_W-1:0] !== want.sum) begin
            $error("running_sum mismatch: expected %h, actual %h",
                   want.sum, out_tdata[SUM_W-1:0]);
            errors++;
          end
          if (out_tdata[SUM_W] !== want.odd) begin
            $error("odd_phase mismatch: expected %b, actual %b",
                   want.odd, out_tdata[SUM_W]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        checksum_acc = checksum_advance(checksum_acc, in_tdata[DATA_W-1:0],
                                        in_tdata[DATA_W +: COUNT_W], in_tuser);
        expected_sums.push_back(checksum_acc);
      end
    end
    fail_count <= errors;
    pending    <= expected_sums.size();
  end

endmodule

// File: tb/tb.sv
// Top-level testbench for ones_complement_sum_stream: clock, reset, input stimulus,
// result-side back pressure, watchdog and verdict. Depends on ocs_pkg and ocs_stream_checker.
`timescale 1ns / 1ps

module tb
  import ocs_pkg::*;
;

  localparam int TOTAL_ITEMS  = 1850;
  localparam int QUIET_ITEMS  = 150;   // Final stretch with no idling on either side.
  localparam int HOLD_AT      = 600;   // Item count at which the receiver holds off.
  localparam int PAUSE_AT     = 1200;  // Item count at which the sender drains the block.
  localparam int LONG_HOLD    = 300;   // Cycles of the long receiver hold-off.
  localparam int STALL_LIMIT  = 2000;  // Cycles with no transaction before giving up.
  localparam int DRAIN_CYCLES = 8;     // Extra cycles after the last expected result.

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_bytes[63:0], byte_count[67:64], zero fill.
  logic                   in_tuser;   // start_new.
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // running_sum[15:0], odd_phase[16], zero fill.

  int   fail_count;
  int   pending;
  int   hold_asked;
  logic quiet;
  int   items_sent;

  ones_complement_sum_stream #(.LANES(LANES_DEF)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ocs_stream_checker #(.LANES(LANES_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one input transaction and holds it until the block accepts it. Afterward
  // the sender may go idle for a short burst; otherwise tvalid simply stays high
  // and the next call only updates the payload.
  task automatic send_item(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count,
                           input logic start);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - DATA_W - COUNT_W){1'b0}}, count, data};
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Result-side back pressure. Each pass drives tready once and then waits on the clock.
  // A long hold-off, asked for by the stimulus process, is counted here.
  initial begin : result_sink
    int hold_served;
    hold_served = 0;
    forever begin
      if (hold_asked != hold_served) begin
        hold_served++;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
    logic               start;
    int                 frame_left;
    int                 pick;
    bit                 hold_done;
    bit                 pause_done;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    hold_asked = 0;
    quiet      = 1'b0;
    items_sent = 0;
    frame_left = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty transaction straight after reset returns the reset state.
    send_item(64'h0, 4'd0, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd8, 1'b1);
    // An empty transaction leaves the sum and the phase unchanged.
    send_item(64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
    // Counts above the lane count saturate.
    send_item({DATA_W{1'b1}}, 4'd15, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd9, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd12, 1'b1);
    // A clear with an empty count returns zero.
    send_item({DATA_W{1'b1}}, 4'd0, 1'b1);
    // All-zero bytes keep the sum at zero.
    send_item(64'h0, 4'd8, 1'b0);
    // Nonzero totals congruent to zero read as all ones.
    send_item(64'h0000_0000_0000_FFFF, 4'd2, 1'b1);
    send_item(64'h0000_0000_7FFF_8000, 4'd4, 1'b1);
    send_item({DATA_W{1'b1}}, 4'd8, 1'b0);
    // Odd counts carry the byte phase across transactions.
    send_item(64'h0000_0000_0000_0001, 4'd1, 1'b1);
    send_item(64'h0000_0000_0000_00AB, 4'd1, 1'b0);
    send_item(64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, 4'd5, 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, 4'd7, 1'b0);
    send_item(64'h8000_0000_0000_0000, 4'd8, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd6, 1'b0);
    send_item(64'h5555_5555_5555_5555, 4'd8, 1'b1);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd10, 1'b0);
    send_item({DATA_W{1'b1}}, 4'd14, 1'b0);

    // Random part: mostly packets that open with a clear and carry full or partial
    // words, mixed with noise transactions that may clear in mid-packet.
    while (items_sent < TOTAL_ITEMS) begin
      data = {$urandom(), $urandom()};
      if ($urandom_range(0, 9) == 0) begin
        start = 1'(($urandom_range(0, 1)));
        count = 4'($urandom_range(0, 15));
      end else begin
        if (frame_left == 0) begin
          frame_left = $urandom_range(1, 40);
          start      = 1'b1;
        end else begin
          start = 1'b0;
        end
        frame_left--;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          count = 4'd8;
        end else if (pick < 9) begin
          count = 4'($urandom_range(0, 8));
        end else begin
          count = 4'($urandom_range(9, 15));
        end
      end
      send_item(data, count, start);

      // The receiver holds off for a long stretch while the sender keeps offering.
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_asked <= hold_asked + 1;
      end
      // The sender waits once until every expected result has come.
      if (!pause_done && items_sent >= PAUSE_AT) begin
        pause_done = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
        quiet <= 1'b1;
      end
    end

    // Drain: wait for the last result, then wait out DRAIN_CYCLES for anything stray.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ocs_pkg.sv
hw/rtl/ones_complement_sum_stream.sv
tb/ocs_stream_checker.sv
tb/tb.sv
